// File: rtl/core/rag_pkg.sv
// Package for the rational arithmetic core: operation codes and field widths.
// No dependencies; imported by rational_arith_gcd_normalize_core.
package rag_pkg;

  localparam int OP_W  = 2;
  localparam int IN_W  = 31;
  localparam int PRD_W = 2 * IN_W;    // signed product width
  localparam int MAG_W = 62;          // magnitude width of num/den
  localparam int NUM_W = 63;          // signed result numerator
  localparam int DEN_W = 62;          // result denominator
  localparam int SH_W  = 6;           // shift/iteration counter

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_CMP = 2'd3
  } op_t;

endpackage

// File: rtl/core/rational_arith_gcd_normalize_core.sv
// Rational arithmetic core: add, multiply, divide and compare of two fractions.
// Depends on rag_pkg.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been formed. Each item forms its products in one
// shared 31x31 multiplier. A reduced item then runs a binary gcd loop (one
// compare, subtract and shift per cycle on 62-bit values) and a restoring
// divider that produces one quotient bit per cycle, run twice to reduce
// numerator and denominator. Compare, zero-numerator and zero-denominator
// items finish in S_PREP without the gcd loop and divider. The result is
// shown for exactly one cycle with out_valid high and cannot be held off.
module rational_arith_gcd_normalize_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rag_pkg::OP_W-1:0]           in_req_type,
  input  logic signed [rag_pkg::IN_W-1:0]    in_a_num,
  input  logic signed [rag_pkg::IN_W-1:0]    in_a_den,
  input  logic signed [rag_pkg::IN_W-1:0]    in_b_num,
  input  logic signed [rag_pkg::IN_W-1:0]    in_b_den,
  output logic                               out_valid,
  output logic signed [rag_pkg::NUM_W-1:0]   out_res_num,
  output logic [rag_pkg::DEN_W-1:0]          out_res_den,
  output logic                               out_less,
  output logic                               out_greater,
  output logic                               out_equal,
  output logic                               out_status
);
  import rag_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_GCD,
    S_DIV
  } state_t;

  state_t                   state_r;
  logic [SH_W-1:0]          cnt_r;
  logic                     pass_r;
  op_t                      op_r;
  logic signed [IN_W-1:0]   an_r, ad_r, bn_r, bd_r;
  logic signed [PRD_W-1:0]  p0_r, p1_r, p2_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         nmag_r, dmag_r;
  logic [MAG_W-1:0]         x_r, y_r, g_r;
  logic [SH_W-1:0]          k_r;
  logic [MAG_W-1:0]         rem_r, quo_r, nq_r;

  logic                     out_valid_r;
  logic signed [NUM_W-1:0]  res_num_r;
  logic [DEN_W-1:0]         res_den_r;
  logic                     less_r, greater_r, equal_r, status_r;

  // shared multiplier operand selection
  logic signed [IN_W-1:0]   mul_a, mul_b;
  logic signed [PRD_W-1:0]  prod;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase
  end

  assign prod = PRD_W'(mul_a) * PRD_W'(mul_b);

  // combine products into signed numerator and denominator
  logic signed [NUM_W-1:0]  num_s;
  logic signed [NUM_W-1:0]  den_s;
  logic [NUM_W-1:0]         num_abs, den_abs;
  logic signed [PRD_W-1:0]  lhs, rhs;
  logic                     swap;

  always_comb begin
    num_s   = NUM_W'(p0_r) + ((op_r == OP_ADD) ? NUM_W'(p1_r) : '0);
    den_s   = NUM_W'(p2_r);
    num_abs = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    den_abs = den_s[NUM_W-1] ? NUM_W'(-den_s) : NUM_W'(den_s);
    swap    = ad_r[IN_W-1] != bd_r[IN_W-1];
    lhs     = swap ? p1_r : p0_r;
    rhs     = swap ? p0_r : p1_r;
  end

  // restoring divider step
  logic [MAG_W:0]   trial;
  logic             q_bit;
  logic [MAG_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[MAG_W-1]};
    q_bit   = trial >= {1'b0, g_r};
    rem_nxt = q_bit ? MAG_W'(trial - {1'b0, g_r}) : trial[MAG_W-1:0];
  end

  // binary gcd step
  logic [MAG_W-1:0] diff_xy, diff_yx;
  logic             x_ge_y;

  always_comb begin
    x_ge_y  = x_r >= y_r;
    diff_xy = x_r - y_r;
    diff_yx = y_r - x_r;
  end

  // sequencer, datapath registers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(in_req_type);
            an_r    <= in_a_num;
            ad_r    <= in_a_den;
            bn_r    <= in_b_num;
            bd_r    <= in_b_den;
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          case (cnt_r[1:0])
            2'd0:    p0_r <= prod;
            2'd1:    p1_r <= prod;
            default: p2_r <= prod;
          endcase
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[1:0] == 2'd2) state_r <= S_PREP;
        end
        S_PREP: begin
          res_num_r <= '0;
          res_den_r <= '0;
          less_r    <= 1'b0;
          greater_r <= 1'b0;
          equal_r   <= 1'b0;
          status_r  <= 1'b0;
          state_r   <= S_IDLE;
          if (ad_r == '0 || bd_r == '0) begin
            status_r    <= 1'b1;
            out_valid_r <= 1'b1;
          end else if (op_r == OP_CMP) begin
            less_r      <= lhs < rhs;
            greater_r   <= lhs > rhs;
            equal_r     <= lhs == rhs;
            out_valid_r <= 1'b1;
          end else if (den_s == '0) begin
            status_r    <= 1'b1;
            out_valid_r <= 1'b1;
          end else if (num_s == '0) begin
            res_den_r   <= DEN_W'(1);
            out_valid_r <= 1'b1;
          end else begin
            neg_r   <= num_s[NUM_W-1] != den_s[NUM_W-1];
            nmag_r  <= num_abs[MAG_W-1:0];
            dmag_r  <= den_abs[MAG_W-1:0];
            x_r     <= num_abs[MAG_W-1:0];
            y_r     <= den_abs[MAG_W-1:0];
            k_r     <= '0;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (x_r == y_r) begin
            g_r     <= x_r << k_r;
            rem_r   <= '0;
            quo_r   <= nmag_r;
            cnt_r   <= '0;
            pass_r  <= 1'b0;
            state_r <= S_DIV;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_ge_y) begin
            x_r <= diff_xy >> 1;
          end else begin
            y_r <= diff_yx >> 1;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[MAG_W-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SH_W'(MAG_W - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (!pass_r) begin
              nq_r   <= {quo_r[MAG_W-2:0], q_bit};
              quo_r  <= dmag_r;
              pass_r <= 1'b1;
            end else begin
              res_num_r   <= neg_r ? -NUM_W'(nq_r) : NUM_W'(nq_r);
              res_den_r   <= {quo_r[MAG_W-2:0], q_bit};
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy        = state_r != S_IDLE;
  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_less    = less_r;
  assign out_greater = greater_r;
  assign out_equal   = equal_r;
  assign out_status  = status_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for rational_arith_gcd_normalize_core.
// Depends on rag_pkg and the core; drives fraction items and checks each result.
`timescale 1ns / 1ps

module testbench;
  import rag_pkg::*;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    less;
    logic                    greater;
    logic                    equal;
    logic                    status;
  } frac_result_t;

  int unsigned error_count = 0;

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Holds expected fraction results and checks outputs against them
  class FracScoreboard;
    frac_result_t pending[$];
    int unsigned  n_checked;

    static function longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // Work out the expected result for one accepted item
    function void note_item(op_t op, logic signed [IN_W-1:0] an_i,
                            logic signed [IN_W-1:0] ad_i,
                            logic signed [IN_W-1:0] bn_i,
                            logic signed [IN_W-1:0] bd_i);
      frac_result_t    r;
      longint          an, ad, bn, bd, lhs, rhs, t, num, den;
      longint unsigned nmag, dmag, g;
      logic            neg;
      r = '{default: '0};
      an = an_i; ad = ad_i; bn = bn_i; bd = bd_i;
      if (ad == 0 || bd == 0) begin
        r.status = 1'b1;
      end else if (op == OP_CMP) begin
        lhs = an * bd;
        rhs = bn * ad;
        if ((ad < 0) != (bd < 0)) begin
          t = lhs; lhs = rhs; rhs = t;
        end
        r.less    = lhs < rhs;
        r.greater = lhs > rhs;
        r.equal   = lhs == rhs;
      end else begin
        case (op)
          OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
          OP_MUL: begin num = an * bn; den = ad * bd; end
          default: begin num = an * bd; den = ad * bn; end
        endcase
        if (den == 0) begin
          r.status = 1'b1;
        end else begin
          neg  = (num < 0) != (den < 0);
          nmag = (num < 0) ? -num : num;
          dmag = (den < 0) ? -den : den;
          if (nmag == 0) begin
            dmag = 1;
            neg  = 1'b0;
          end else begin
            g = euclid_gcd(nmag, dmag);
            nmag = nmag / g;
            dmag = dmag / g;
          end
          r.num = neg ? -nmag : nmag;
          r.den = dmag;
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one output result with the oldest expectation
    task check_result(frac_result_t got);
      frac_result_t e;
      if (pending.size() == 0) begin
        report("result with no item pending");
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.num !== e.num)
        report($sformatf("res_num got %0d exp %0d", got.num, e.num));
      if (got.den !== e.den)
        report($sformatf("res_den got %0d exp %0d", got.den, e.den));
      if (got.less !== e.less)
        report($sformatf("less got %b exp %b", got.less, e.less));
      if (got.greater !== e.greater)
        report($sformatf("greater got %b exp %b", got.greater, e.greater));
      if (got.equal !== e.equal)
        report($sformatf("equal got %b exp %b", got.equal, e.equal));
      if (got.status !== e.status)
        report($sformatf("status got %b exp %b", got.status, e.status));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_req_type = '0;
  logic signed [IN_W-1:0]  in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic                    out_valid;
  logic signed [NUM_W-1:0] out_res_num;
  logic [DEN_W-1:0]        out_res_den;
  logic                    out_less, out_greater, out_equal, out_status;

  FracScoreboard sb = new();
  int            sender_idle_pct = 0;
  longint        cycle_count = 0;
  int unsigned   op_count[4] = '{0, 0, 0, 0};

  localparam longint CYCLE_LIMIT = 2_000_000;

  rational_arith_gcd_normalize_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_less(out_less), .out_greater(out_greater), .out_equal(out_equal),
    .out_status(out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample results and count cycles at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
    if (rst_n && out_valid)
      sb.check_result('{out_res_num, out_res_den, out_less, out_greater,
                        out_equal, out_status});
  end

  // Present one item and hold it until the core takes it
  task automatic send_item(op_t op, logic signed [IN_W-1:0] an, logic signed [IN_W-1:0] ad,
                           logic signed [IN_W-1:0] bn, logic signed [IN_W-1:0] bd);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= op;
    in_a_num    <= an;
    in_a_den    <= ad;
    in_b_num    <= bn;
    in_b_den    <= bd;
    do @(posedge clk); while (busy);
    sb.note_item(op, an, ad, bn, bd);
    op_count[op]++;
    @(negedge clk);
  endtask

  // Pick a field value: mostly small, sometimes zero, full range or extreme
  function automatic logic signed [IN_W-1:0] rand_field();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 31'sh3FFFFFFF : 31'sh40000000;
      1, 2, 3: return 31'($urandom);
      4: return 0;
      default: return $signed(31'($urandom_range(40))) - 31'sd20;
    endcase
  endfunction

  localparam logic signed [IN_W-1:0] MAXV = 31'sh3FFFFFFF;
  localparam logic signed [IN_W-1:0] MINV = 31'sh40000000;

  initial begin
    op_t ops[4];
    ops = '{OP_ADD, OP_MUL, OP_DIV, OP_CMP};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each operation, zero cases
    foreach (ops[i]) begin
      send_item(ops[i], MAXV, MAXV, MAXV, MAXV);
      send_item(ops[i], MINV, MINV, MINV, MINV);
      send_item(ops[i], MINV, 31'sd1, MAXV, -31'sd1);
      send_item(ops[i], 31'sd3, 31'sd0, 31'sd5, 31'sd7);
      send_item(ops[i], 31'sd0, 31'sd4, 31'sd0, -31'sd9);
    end
    send_item(OP_DIV, 31'sd6, 31'sd4, 31'sd0, 31'sd3);
    send_item(OP_ADD, 31'sd1, 31'sd2, -31'sd1, 31'sd2);
    send_item(OP_CMP, 31'sd1, -31'sd2, 31'sd1, 31'sd2);
    send_item(OP_CMP, 31'sd2, 31'sd4, -31'sd1, -31'sd2);

    // Random items over idling phases
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1 || ph == 2) ? 68 : (ph == 3 ? 6 : 0);
      repeat (132) send_item(op_t'($urandom_range(3)), rand_field(), rand_field(),
                             rand_field(), rand_field());
    end
    start <= 1'b0;

    // Drain, then allow the core's latency to pass
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d add, %0d mul, %0d div, %0d cmp items; %0d results checked",
             op_count[0], op_count[1], op_count[2], op_count[3], sb.n_checked);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/rag_pkg.sv
rtl/core/rational_arith_gcd_normalize_core.sv
tb/testbench.sv
